// ===== hdl/ssmh_pkg.sv =====
// ----------------------------------------------------------------------------
// ssmh_pkg: shared types and constants for the swept spectrum max-hold block
// Word formats of the measurement and result channels, configuration
// register indices and reset levels.
// ----------------------------------------------------------------------------
package ssmh_pkg;

  // Configuration register indices, in register order.
  typedef enum logic [1:0] {
    CFG_START_FREQ = 2'd0,
    CFG_END_FREQ   = 2'd1,
    CFG_FLOOR      = 2'd2,
    CFG_CEILING    = 2'd3
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset levels in dBm.
  localparam logic signed [7:0] FLOOR_RST   = -8'sd120;
  localparam logic signed [7:0] CEILING_RST = -8'sd52;

  // Operation codes of a measurement word.
  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  typedef struct packed {
    logic              operation;
    logic signed [7:0] level_dbm;
    logic              level_valid;
  } in_word_t;

  // Everything of a result except the frequency, which is finished later.
  typedef struct packed {
    logic [5:0]        bin_index;
    logic signed [7:0] live_dbm;
    logic signed [7:0] hold_dbm;
    logic              wrapped;
    logic [31:0]       sweep_count;
    logic [5:0]        peak_bin;
    logic signed [7:0] peak_dbm;
  } bin_info_t;

  typedef struct packed {
    logic [5:0]        bin_index;
    logic signed [7:0] live_dbm;
    logic signed [7:0] hold_dbm;
    logic [31:0]       next_freq_hz;
    logic              wrapped;
    logic [31:0]       sweep_count;
    logic [5:0]        peak_bin;
    logic signed [7:0] peak_dbm;
  } out_word_t;

endpackage

// ===== hdl/ssmh_stream_if.sv =====
// ----------------------------------------------------------------------------
// ssmh_stream_if: valid/ready stream channel
// Carries one word per handshake; the word type is set by the instantiator.
// ----------------------------------------------------------------------------
interface ssmh_stream_if #(
  parameter type word_t = logic
) ();

  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== hdl/swept_spectrum_max_hold_top.sv =====
// ----------------------------------------------------------------------------
// swept_spectrum_max_hold_top: swept spectrum analyzer with max-hold trace
// Pipeline: eight register stages, set by the bin frequency division.
// Throughput: one word per cycle while the output is not stalled, set by
// the single read-modify-write of the level memory at the cursor, whose
// next entry is prefetched by a registered read.
// Reset: immediate, no clearing pass; stores read as the floor level.
// ----------------------------------------------------------------------------
module swept_spectrum_max_hold_top #(
  parameter int unsigned BIN_COUNT = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ssmh_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ssmh_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ssmh_stream_if.sink                   in_if,
  ssmh_stream_if.source                 out_if
);

  // Cursor width and the constant divisor of the bin frequency formula.
  localparam int unsigned KW     = $clog2(BIN_COUNT);
  localparam int unsigned BKW    = 2 * KW;
  localparam int unsigned DIV_D  = BIN_COUNT - 1;
  localparam int unsigned DIV_L  = $clog2(DIV_D);
  localparam int unsigned NSTAGE = 8;

  // Reciprocals for division by DIV_D. An estimate taken with these is low
  // by at most one, so a single compare and subtract finishes the division.
  localparam logic [63:0] M1_FULL = (64'd1 << (32 + DIV_L)) / 64'(DIV_D);
  localparam logic [32:0] M1      = 33'(M1_FULL);
  localparam int unsigned M2W     = BKW + 1;
  localparam logic [63:0] M2_FULL = (64'd1 << (BKW + DIV_L)) / 64'(DIV_D);
  localparam logic [M2W-1:0] M2   = M2W'(M2_FULL);

  localparam logic [KW-1:0]  LAST_BIN = KW'(DIV_D);
  localparam logic [31:0]    D_32     = 32'(DIV_D);
  localparam logic [BKW-1:0] D_BK     = BKW'(DIV_D);

  // --------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  // --------------------------------------------------------------------------
  logic [31:0]       start_q;
  logic [31:0]       end_q;
  logic signed [7:0] floor_q;
  logic signed [7:0] ceiling_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q   <= '0;
      end_q     <= '0;
      floor_q   <= ssmh_pkg::FLOOR_RST;
      ceiling_q <= ssmh_pkg::CEILING_RST;
    end else if (cfg_we_i) begin
      unique case (ssmh_pkg::cfg_reg_e'(cfg_idx_i))
        ssmh_pkg::CFG_START_FREQ: start_q   <= cfg_data_i;
        ssmh_pkg::CFG_END_FREQ:   end_q     <= cfg_data_i;
        ssmh_pkg::CFG_FLOOR:      floor_q   <= cfg_data_i[7:0];
        ssmh_pkg::CFG_CEILING:    ceiling_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. The whole pipeline moves together whenever the output
  // register is empty or being drained, so a new word is taken in the same
  // cycle that a finished result leaves.
  // --------------------------------------------------------------------------
  logic [NSTAGE-1:0] vld_q;
  logic              adv;
  logic              accept;

  assign adv          = ~vld_q[NSTAGE-1] | out_if.ready;
  assign in_if.ready  = adv;
  assign accept       = in_if.valid & adv;

  // --------------------------------------------------------------------------
  // Sweep state.
  // A restart does not touch the memory. Instead the level in force at the
  // restart is kept in clear_lvl_q, and swept_q tells whether the cursor has
  // gone once round since then. The cursor walks the bins in order, so the
  // entry under the cursor holds live data exactly when swept_q is set;
  // otherwise it reads as the cleared level.
  // --------------------------------------------------------------------------
  logic [KW-1:0]     cursor_q, cursor_d;
  logic [31:0]       sweeps_q, sweeps_d;
  logic [KW-1:0]     peak_idx_q, peak_idx_d;
  logic signed [7:0] peak_lvl_q, peak_lvl_d;
  logic signed [7:0] clear_lvl_q, clear_lvl_d;
  logic              swept_q, swept_d;

  // Level memory: live level in the upper byte, hold level in the lower.
  logic [15:0] lvl_mem [BIN_COUNT];
  logic [15:0] rd_q;
  logic        mem_we;
  logic [15:0] mem_wdata;

  logic signed [7:0] old_live, old_hold, clamped, new_live, new_hold;
  logic              raise, wrap;

  ssmh_pkg::bin_info_t info_d;
  logic [31:0]         span_d;

  always_comb begin
    old_live = swept_q ? rd_q[15:8] : clear_lvl_q;
    old_hold = swept_q ? rd_q[7:0]  : clear_lvl_q;

    // Floor test first, so a floor above the ceiling still wins.
    if (in_if.data.level_dbm < floor_q) begin
      clamped = floor_q;
    end else if (in_if.data.level_dbm > ceiling_q) begin
      clamped = ceiling_q;
    end else begin
      clamped = in_if.data.level_dbm;
    end

    raise    = in_if.data.level_valid & (clamped > old_hold);
    new_live = in_if.data.level_valid ? clamped : old_live;
    new_hold = raise ? clamped : old_hold;
    wrap     = (cursor_q == LAST_BIN);
  end

  always_comb begin
    cursor_d    = cursor_q;
    sweeps_d    = sweeps_q;
    peak_idx_d  = peak_idx_q;
    peak_lvl_d  = peak_lvl_q;
    clear_lvl_d = clear_lvl_q;
    swept_d     = swept_q;
    mem_we      = 1'b0;
    mem_wdata   = {new_live, new_hold};
    info_d      = '0;

    if (in_if.data.operation == ssmh_pkg::OP_RESTART) begin
      cursor_d    = '0;
      sweeps_d    = '0;
      peak_idx_d  = '0;
      peak_lvl_d  = floor_q;
      clear_lvl_d = floor_q;
      swept_d     = 1'b0;
      info_d.bin_index   = '0;
      info_d.live_dbm    = floor_q;
      info_d.hold_dbm    = floor_q;
      info_d.wrapped     = 1'b0;
      info_d.sweep_count = '0;
      info_d.peak_bin    = '0;
      info_d.peak_dbm    = floor_q;
    end else begin
      // The entry is always written back, so a bin passed with no reading
      // turns the cleared level into real memory content.
      mem_we = 1'b1;
      if (raise && ((clamped > peak_lvl_q) ||
                    ((clamped == peak_lvl_q) && (cursor_q < peak_idx_q)))) begin
        peak_lvl_d = clamped;
        peak_idx_d = cursor_q;
      end
      if (wrap) begin
        cursor_d = '0;
        sweeps_d = sweeps_q + 32'd1;
        swept_d  = 1'b1;
      end else begin
        cursor_d = cursor_q + KW'(1);
      end
      info_d.bin_index   = 6'(cursor_q);
      info_d.live_dbm    = new_live;
      info_d.hold_dbm    = new_hold;
      info_d.wrapped     = wrap;
      info_d.sweep_count = sweeps_d;
      info_d.peak_bin    = 6'(peak_idx_d);
      info_d.peak_dbm    = peak_lvl_d;
    end

    if (!accept) begin
      cursor_d    = cursor_q;
      sweeps_d    = sweeps_q;
      peak_idx_d  = peak_idx_q;
      peak_lvl_d  = peak_lvl_q;
      clear_lvl_d = clear_lvl_q;
      swept_d     = swept_q;
      mem_we      = 1'b0;
    end

    span_d = (end_q > start_q) ? (end_q - start_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q    <= '0;
      sweeps_q    <= '0;
      peak_idx_q  <= '0;
      peak_lvl_q  <= ssmh_pkg::FLOOR_RST;
      clear_lvl_q <= ssmh_pkg::FLOOR_RST;
      swept_q     <= 1'b0;
    end else begin
      cursor_q    <= cursor_d;
      sweeps_q    <= sweeps_d;
      peak_idx_q  <= peak_idx_d;
      peak_lvl_q  <= peak_lvl_d;
      clear_lvl_q <= clear_lvl_d;
      swept_q     <= swept_d;
    end
  end

  // The write goes to the old cursor while the read fetches the new one.
  // With at least two bins these never coincide, so the prefetched entry is
  // always current and no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      lvl_mem[cursor_q] <= mem_wdata;
    end
    rd_q <= lvl_mem[cursor_d];
  end

  // --------------------------------------------------------------------------
  // Frequency pipeline: next_freq = start + floor(span * k / D), D = bins - 1.
  // With span = a * D + b and b < D this is a * k + floor(b * k / D), so
  // the wide division shrinks to one 32-bit and one narrow constant
  // division, each a reciprocal multiply followed by one correction.
  // --------------------------------------------------------------------------
  ssmh_pkg::bin_info_t info_q [NSTAGE];
  logic [31:0]         start_p_q [NSTAGE-1];

  logic [31:0]     span1_q, span2_q, span3_q;
  logic [KW-1:0]   k1_q, k2_q, k3_q, k4_q;
  logic [31:0]     a0_2_q, a0_3_q, ad3_q, a4_q;
  logic [KW-1:0]   b4_q;
  logic [31:0]     ak5_q, ak6_q, ak7_q;
  logic [BKW-1:0]  bk5_q, bk6_q, bk7_q, cd7_q;
  logic [KW-1:0]   c0_6_q, c0_7_q;
  logic [31:0]     freq8_q;

  logic [64:0]         recip1;
  logic [31:0]         rem4;
  logic                fix4;
  logic [BKW+M2W-1:0]  recip2;
  logic                fix8;

  assign recip1 = 65'(span1_q) * 65'(M1);
  assign rem4   = span3_q - ad3_q;
  assign fix4   = (rem4 >= D_32);
  assign recip2 = (BKW + M2W)'(bk5_q) * (BKW + M2W)'(M2);
  assign fix8   = ((bk7_q - cd7_q) >= D_BK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTAGE-2:0], accept};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      info_q[0]    <= info_d;
      start_p_q[0] <= start_q;
      span1_q      <= span_d;
      k1_q         <= cursor_d;
      for (int s = 1; s < NSTAGE; s++) begin
        info_q[s] <= info_q[s-1];
      end
      for (int s = 1; s < NSTAGE - 1; s++) begin
        start_p_q[s] <= start_p_q[s-1];
      end

      // First estimate of a = span / D.
      a0_2_q  <= 32'(recip1 >> (32 + DIV_L));
      span2_q <= span1_q;
      k2_q    <= k1_q;

      ad3_q   <= 32'(a0_2_q * D_32);
      a0_3_q  <= a0_2_q;
      span3_q <= span2_q;
      k3_q    <= k2_q;

      // Correct the estimate; b is the remainder of span / D.
      a4_q <= a0_3_q + 32'(fix4);
      b4_q <= KW'(fix4 ? (rem4 - D_32) : rem4);
      k4_q <= k3_q;

      ak5_q <= 32'(a4_q * 32'(k4_q));
      bk5_q <= BKW'(b4_q) * BKW'(k4_q);

      c0_6_q <= KW'(recip2 >> (BKW + DIV_L));
      bk6_q  <= bk5_q;
      ak6_q  <= ak5_q;

      cd7_q  <= BKW'(BKW'(c0_6_q) * D_BK);
      c0_7_q <= c0_6_q;
      bk7_q  <= bk6_q;
      ak7_q  <= ak6_q;

      freq8_q <= start_p_q[NSTAGE-2] + ak7_q + 32'(c0_7_q) + 32'(fix8);
    end
  end

  // --------------------------------------------------------------------------
  // Result word.
  // --------------------------------------------------------------------------
  assign out_if.valid             = vld_q[NSTAGE-1];
  assign out_if.data.bin_index    = info_q[NSTAGE-1].bin_index;
  assign out_if.data.live_dbm     = info_q[NSTAGE-1].live_dbm;
  assign out_if.data.hold_dbm     = info_q[NSTAGE-1].hold_dbm;
  assign out_if.data.next_freq_hz = freq8_q;
  assign out_if.data.wrapped      = info_q[NSTAGE-1].wrapped;
  assign out_if.data.sweep_count  = info_q[NSTAGE-1].sweep_count;
  assign out_if.data.peak_bin     = info_q[NSTAGE-1].peak_bin;
  assign out_if.data.peak_dbm     = info_q[NSTAGE-1].peak_dbm;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for swept_spectrum_max_hold_top
// Drives measurement and restart words into the analyzer, keeps its own
// model of the live and max-hold traces, the sweep cursor and the peak, and
// compares every result word field by field. Configuration is rewritten
// between phases while the block is idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned BINS       = 64;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned DRAIN_WAIT = 12;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [ssmh_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [ssmh_pkg::CFG_DATA_W-1:0] cfg_data_i;

  ssmh_stream_if #(.word_t(ssmh_pkg::in_word_t))  in_ch ();
  ssmh_stream_if #(.word_t(ssmh_pkg::out_word_t)) out_ch ();

  swept_spectrum_max_hold_top #(
    .BIN_COUNT (BINS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the configuration registers, updated when a write lands.
  logic [31:0]       cfg_start;
  logic [31:0]       cfg_end;
  logic signed [7:0] cfg_floor;
  logic signed [7:0] cfg_ceiling;

  // Our own copy of the analyzer state.
  logic signed [7:0] live_trace [BINS];
  logic signed [7:0] hold_trace [BINS];
  int unsigned       cursor_bin;
  logic [31:0]       sweeps_done;
  int unsigned       peak_idx;
  logic signed [7:0] peak_lvl;

  // Result words still owed by the block, oldest first.
  ssmh_pkg::out_word_t expected_bins [$];
  ssmh_pkg::out_word_t bin_due;

  int unsigned items_sent;
  int unsigned restarts_sent;
  int unsigned wraps_seen;
  int unsigned results_checked;
  int unsigned mismatches;

  // Idling controls shared between the stimulus and the receiver.
  bit tx_idle_en;
  bit rx_idle_en;
  bit rx_long_hold;

  // --------------------------------------------------------------------------
  // Trace model
  // --------------------------------------------------------------------------

  // Restart wipes both traces to whatever floor is programmed right now.
  function automatic void clear_traces();
    for (int i = 0; i < BINS; i++) begin
      live_trace[i] = cfg_floor;
      hold_trace[i] = cfg_floor;
    end
    cursor_bin  = 0;
    sweeps_done = '0;
    peak_idx    = 0;
    peak_lvl    = cfg_floor;
  endfunction

  // Frequency of a bin: start plus span * bin / (bins - 1), truncating.
  // An end frequency at or below the start collapses the span to zero.
  function automatic logic [31:0] bin_freq(input int unsigned bin);
    logic [63:0] span;
    span = (cfg_end > cfg_start) ? 64'(cfg_end - cfg_start) : 64'd0;
    return cfg_start + 32'((span * 64'(bin)) / 64'(BINS - 1));
  endfunction

  // Applies one input word to the model and returns the result it causes.
  function automatic ssmh_pkg::out_word_t predict_spectrum(input ssmh_pkg::in_word_t w);
    ssmh_pkg::out_word_t r;
    int unsigned         bin;
    logic signed [7:0]   lvl;
    logic                wrap;
    wrap = 1'b0;
    if (w.operation == ssmh_pkg::OP_RESTART) begin
      clear_traces();
      bin = 0;
    end else begin
      bin = cursor_bin;
      if (w.level_valid) begin
        // The floor test comes first, so an inverted pair of limits still
        // lifts low readings to the floor.
        if ($signed(w.level_dbm) < cfg_floor) begin
          lvl = cfg_floor;
        end else if ($signed(w.level_dbm) > cfg_ceiling) begin
          lvl = cfg_ceiling;
        end else begin
          lvl = w.level_dbm;
        end
        live_trace[bin] = lvl;
        if (lvl > hold_trace[bin]) begin
          hold_trace[bin] = lvl;
          if (lvl > peak_lvl || (lvl == peak_lvl && bin < peak_idx)) begin
            peak_lvl = lvl;
            peak_idx = bin;
          end
        end
      end
      cursor_bin = bin + 1;
      if (cursor_bin >= BINS) begin
        cursor_bin  = 0;
        sweeps_done = sweeps_done + 32'd1;
        wrap        = 1'b1;
      end
    end
    r.bin_index    = 6'(bin);
    r.live_dbm     = live_trace[bin];
    r.hold_dbm     = hold_trace[bin];
    r.next_freq_hz = bin_freq(cursor_bin);
    r.wrapped      = wrap;
    r.sweep_count  = sweeps_done;
    r.peak_bin     = 6'(peak_idx);
    r.peak_dbm     = peak_lvl;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d, %s: expected 'h%0h, got 'h%0h",
                 results_checked, name, want, got);
      end
    end
  endfunction

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result word for bin %0d", out_ch.data.bin_index);
        end
      end else begin
        bin_due = expected_bins.pop_front();
        check_field("bin_index",    bin_due.bin_index,    out_ch.data.bin_index);
        check_field("live_dbm",     bin_due.live_dbm,     out_ch.data.live_dbm);
        check_field("hold_dbm",     bin_due.hold_dbm,     out_ch.data.hold_dbm);
        check_field("next_freq_hz", bin_due.next_freq_hz, out_ch.data.next_freq_hz);
        check_field("wrapped",      bin_due.wrapped,      out_ch.data.wrapped);
        check_field("sweep_count",  bin_due.sweep_count,  out_ch.data.sweep_count);
        check_field("peak_bin",     bin_due.peak_bin,     out_ch.data.peak_bin);
        check_field("peak_dbm",     bin_due.peak_dbm,     out_ch.data.peak_dbm);
        results_checked++;
      end
    end
  end

  // The receiver takes one word per loop. It may sit out a random number of
  // cycles first, and on request it holds off for a long stretch so that the
  // pipeline backs up into the input channel.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    forever begin
      if (rx_long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        rx_long_hold = 1'b0;
      end
      stall = rx_idle_en ? $urandom_range(0, 12) : 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic ssmh_pkg::in_word_t make_word(input logic op, input logic [7:0] lvl,
                                                   input logic vld);
    ssmh_pkg::in_word_t w;
    w.operation   = op;
    w.level_dbm   = lvl;
    w.level_valid = vld;
    return w;
  endfunction

  // Offers one word, after an optional random gap, and records what the
  // block owes for it once the handshake completes. Valid is left high so
  // that the next word can follow without a bubble.
  task automatic send_word(input ssmh_pkg::in_word_t w);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    expected_bins.push_back(predict_spectrum(w));
    if (expected_bins[$].wrapped) wraps_seen++;
    items_sent++;
    if (w.operation == ssmh_pkg::OP_RESTART) restarts_sent++;
  endtask

  task automatic send_measure(input logic [7:0] lvl, input logic vld);
    send_word(make_word(ssmh_pkg::OP_MEASURE, lvl, vld));
  endtask

  task automatic send_restart();
    send_word(make_word(ssmh_pkg::OP_RESTART, 8'($urandom), 1'($urandom)));
  endtask

  // Stops offering words and waits until every owed result has come back,
  // plus a margin longer than the pipeline.
  task automatic settle_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input ssmh_pkg::cfg_reg_e idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ssmh_pkg::CFG_START_FREQ: cfg_start   = value;
      ssmh_pkg::CFG_END_FREQ:   cfg_end     = value;
      ssmh_pkg::CFG_FLOOR:      cfg_floor   = value[7:0];
      ssmh_pkg::CFG_CEILING:    cfg_ceiling = value[7:0];
      default: ;
    endcase
  endtask

  // Level registers only use the low byte; the upper bits carry junk.
  task automatic apply_config(input logic [31:0] start_hz, input logic [31:0] end_hz,
                              input logic signed [7:0] floor_lvl,
                              input logic signed [7:0] ceil_lvl);
    settle_pipeline();
    write_reg(ssmh_pkg::CFG_START_FREQ, start_hz);
    write_reg(ssmh_pkg::CFG_END_FREQ, end_hz);
    write_reg(ssmh_pkg::CFG_FLOOR, {24'($urandom), floor_lvl});
    write_reg(ssmh_pkg::CFG_CEILING, {24'($urandom), ceil_lvl});
  endtask

  function automatic logic signed [7:0] rand_limit();
    case ($urandom_range(0, 5))
      0:       return -8'sd128;
      1:       return 8'sd0;
      default: return 8'(-int'($urandom_range(0, 128)));
    endcase
  endfunction

  // Readings cluster near the limits so that clamping and tied maxima are
  // common, with a share drawn over the whole 8-bit range.
  function automatic logic [7:0] rand_level();
    int lo;
    int hi;
    lo = (cfg_floor < cfg_ceiling) ? cfg_floor : cfg_ceiling;
    hi = (cfg_floor < cfg_ceiling) ? cfg_ceiling : cfg_floor;
    case ($urandom_range(0, 3))
      0:       return 8'($urandom);
      1:       return 8'(int'(cfg_floor) + int'($urandom_range(0, 2)));
      2:       return 8'(int'(cfg_ceiling) - int'($urandom_range(0, 2)));
      default: return 8'(lo + int'($urandom_range(0, hi - lo)));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset limits: readings at both ends of the byte range get clamped, a
  // missing reading still moves the cursor, and restart clears the traces.
  task automatic test_limits_at_reset();
    send_measure(8'sh80, 1'b1);
    send_measure(8'sh7f, 1'b1);
    send_measure(-8'sd80, 1'b1);
    send_measure(-8'sd5, 1'b0);
    send_measure(8'sh00, 1'b1);
    send_restart();
    send_measure(8'shff, 1'b1);
  endtask

  // Full-scale span, then a zero span and an inverted one where every bin
  // sits at the start frequency.
  task automatic test_frequency_span();
    apply_config(32'h0000_0000, 32'hffff_ffff, -8'sd128, 8'sd0);
    send_restart();
    send_measure(8'sh80, 1'b1);
    send_measure(8'sh7f, 1'b1);
    send_measure(-8'sd100, 1'b0);
    apply_config(32'd1000, 32'd1000, -8'sd128, 8'sd0);
    send_measure(-8'sd30, 1'b1);
    send_measure(-8'sd31, 1'b1);
    apply_config(32'hffff_ffff, 32'h0000_0000, -8'sd128, 8'sd0);
    send_measure(-8'sd1, 1'b1);
    send_measure(-8'sd2, 1'b1);
  endtask

  // Floor above ceiling: readings under the floor, including those between
  // the two limits, land on the floor, while higher ones land on the ceiling.
  task automatic test_inverted_limits();
    apply_config(32'd100_000_000, 32'd200_000_000, -8'sd40, -8'sd90);
    send_restart();
    send_measure(-8'sd100, 1'b1);
    send_measure(-8'sd60, 1'b1);
    send_measure(-8'sd20, 1'b1);
    send_measure(-8'sd64, 1'b1);
  endtask

  // The receiver stalls for a long stretch while the sender keeps offering
  // words back to back, then the sender pauses until everything drains.
  task automatic test_backpressure();
    apply_config(32'd2_400_000_000, 32'd2_483_500_000, -8'sd110, -8'sd20);
    send_restart();
    tx_idle_en   = 1'b0;
    rx_long_hold = 1'b1;
    repeat (60) send_measure(rand_level(), 1'b1);
    settle_pipeline();
    repeat (40) send_measure(rand_level(), 1'($urandom_range(0, 3) != 0));
    settle_pipeline();
  endtask

  // Mostly whole sweeps after a restart with random readings, mixed with
  // stray restarts and missing readings. Each phase reprograms all four
  // registers, sometimes without a restart so the old traces carry over.
  task automatic test_random_sweeps();
    logic [31:0]       s_hz;
    logic [31:0]       e_hz;
    logic signed [7:0] fl;
    logic signed [7:0] cl;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          s_hz = 32'h0; e_hz = 32'hffff_ffff; fl = -8'sd128; cl = 8'sd0;
        end
        1: begin
          s_hz = 32'hffff_ffff; e_hz = 32'hffff_ffff; fl = 8'sd0; cl = -8'sd128;
        end
        default: begin
          s_hz = $urandom;
          e_hz = ($urandom_range(0, 3) == 0) ? $urandom : s_hz + $urandom_range(0, 1 << 30);
          fl   = rand_limit();
          cl   = rand_limit();
        end
      endcase
      apply_config(s_hz, e_hz, fl, cl);
      if ($urandom_range(0, 9) < 7) send_restart();
      for (int n = 0; n < 200; n++) begin
        if (n % 50 == 0) begin
          tx_idle_en = ($urandom_range(0, 3) != 0);
          rx_idle_en = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 149) == 0) begin
          send_restart();
        end else begin
          send_measure(rand_level(), 1'($urandom_range(0, 7) != 0));
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = ssmh_pkg::CFG_START_FREQ;
    cfg_data_i  = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    tx_idle_en  = 1'b1;
    rx_idle_en  = 1'b1;

    cfg_start   = '0;
    cfg_end     = '0;
    cfg_floor   = ssmh_pkg::FLOOR_RST;
    cfg_ceiling = ssmh_pkg::CEILING_RST;
    clear_traces();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_limits_at_reset();
    test_frequency_span();
    test_inverted_limits();
    test_backpressure();
    test_random_sweeps();
    settle_pipeline();

    $display("Sent %0d words (%0d restarts) across %0d sweep wraps.",
             items_sent, restarts_sent, wraps_seen);
    $display("Checked %0d result words, %0d field mismatches.",
             results_checked, mismatches);
    if (mismatches == 0 && expected_bins.size() == 0) begin
      $display("swept_spectrum_max_hold_top: match");
    end else begin
      $display("swept_spectrum_max_hold_top: mismatch");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("swept_spectrum_max_hold_top: mismatch");
    $finish;
  end

endmodule
